// File: hw/rtl/hsc_pkg.sv
// hsc_pkg: shared types, widths and position helpers for the hamming sec codec
// used by hsc_core and hamming_sec_codec; no dependencies
`timescale 1ns / 1ps

package hsc_pkg;

  localparam int MaxDataBits = 57;
  localparam int DataW       = 57;
  localparam int CodeW       = 63;
  localparam int LenW        = 6;
  localparam int ChkW        = 6;
  localparam int CntW        = 3;

  typedef enum logic {
    KindEncode  = 1'b0,
    KindCorrect = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [DataW-1:0]   data_in;
    logic [CodeW-1:0]   code_in;
    logic [LenW-1:0]    data_length;
    logic               odd_parity;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0]   code_out;
    logic [ChkW-1:0]    check_bits;
    logic [ChkW-1:0]    error_position;
    logic               bad_syndrome;
  } out_item_t;

  // code position (1-based) of data bit j (0-based), skipping powers of two
  function automatic int data_pos(input int j);
    int pos;
    pos = j + 1;
    for (int k = 0; k < ChkW; k++) begin
      if ((1 << k) <= pos) begin
        pos = pos + 1;
      end
    end
    return pos;
  endfunction

  // data positions covered by check bit i
  function automatic logic [CodeW-1:0] cover_mask(input int i);
    logic [CodeW-1:0] mask;
    mask = '0;
    for (int p = 1; p <= CodeW; p++) begin
      if (((p & (p - 1)) != 0) && (((p >> i) & 1) == 1)) begin
        mask[p-1] = 1'b1;
      end
    end
    return mask;
  endfunction

endpackage

// File: hw/rtl/hsc_core.sv
// hsc_core: combinational encode and check/correct of one code word
// depends on hsc_pkg
`timescale 1ns / 1ps

module hsc_core (
  input  hsc_pkg::in_item_t  item_i,
  output hsc_pkg::out_item_t result_o
);
  import hsc_pkg::*;

  logic [LenW-1:0]  m;
  logic [CntW-1:0]  r;
  logic [LenW-1:0]  n;
  logic [CodeW-1:0] nmask;
  logic [CodeW-1:0] word_enc;
  logic [CodeW-1:0] word_src;
  logic [CodeW-1:0] chk_word;
  logic [CodeW-1:0] flip;
  logic [ChkW-1:0]  checks;
  logic [ChkW-1:0]  syndrome;
  logic             bad;

  always_comb begin
    m = (item_i.data_length > LenW'(MaxDataBits)) ? LenW'(MaxDataBits)
                                                   : item_i.data_length;
    if (m == '0) begin
      r = CntW'(1);
    end else if (m <= LenW'(1)) begin
      r = CntW'(2);
    end else if (m <= LenW'(4)) begin
      r = CntW'(3);
    end else if (m <= LenW'(11)) begin
      r = CntW'(4);
    end else if (m <= LenW'(26)) begin
      r = CntW'(5);
    end else begin
      r = CntW'(6);
    end
    n = m + LenW'(r);
  end

  always_comb begin
    for (int p = 1; p <= CodeW; p++) begin
      nmask[p-1] = (LenW'(p) <= n);
    end
  end

  // scatter data bits onto non power-of-two positions
  always_comb begin
    word_enc = '0;
    for (int j = 0; j < DataW; j++) begin
      word_enc[data_pos(j)-1] = item_i.data_in[j] & (LenW'(j) < m);
    end
  end

  assign word_src = (item_i.kind == KindEncode) ? word_enc : (item_i.code_in & nmask);

  always_comb begin
    for (int i = 0; i < ChkW; i++) begin
      checks[i]   = (CntW'(i) < r) &
                    ((^(word_src & cover_mask(i))) ^ item_i.odd_parity);
      syndrome[i] = (CntW'(i) < r) & (word_src[(1 << i) - 1] != checks[i]);
    end
  end

  assign bad = (item_i.kind == KindCorrect) && (syndrome > n);

  always_comb begin
    chk_word = '0;
    flip     = '0;
    for (int i = 0; i < ChkW; i++) begin
      chk_word[(1 << i) - 1] = checks[i];
    end
    for (int p = 1; p <= CodeW; p++) begin
      flip[p-1] = (syndrome == LenW'(p)) & ~bad;
    end
  end

  always_comb begin
    result_o.check_bits = checks;
    if (item_i.kind == KindEncode) begin
      result_o.code_out       = (word_enc | chk_word) & nmask;
      result_o.error_position = '0;
      result_o.bad_syndrome   = 1'b0;
    end else begin
      result_o.code_out       = (word_src ^ flip) & nmask;
      result_o.error_position = syndrome;
      result_o.bad_syndrome   = bad;
    end
  end

endmodule

// File: hw/rtl/hamming_sec_codec.sv
// hamming_sec_codec: top level, input register, hsc_core, result register
// depends on hsc_pkg and hsc_core
`timescale 1ns / 1ps
//
//   channel | direction | payload             | handshake
//   in      | input     | hsc_pkg::in_item_t  | in_valid_i / in_ready_o
//   out     | output    | hsc_pkg::out_item_t | out_valid_o / out_ready_i
//
// one beat per cycle sustained while out_ready_i stays high
// a result passes through the input register and the result register around hsc_core
// rst_ni clears only the two valid flags; payload registers are not reset
// a stalled result keeps its register while the input register can still fill
// in_ready_o drops only when both registers are full and out_ready_i is low

module hamming_sec_codec (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hsc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hsc_pkg::out_item_t out_data_o
);
  import hsc_pkg::*;

  in_item_t  in_q;
  logic      in_valid_q;
  logic      in_valid_d;
  out_item_t out_q;
  out_item_t out_d;
  logic      out_valid_q;
  logic      out_valid_d;
  logic      advance;

  hsc_core u_core (
    .item_i   (in_q),
    .result_o (out_d)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_ready_o ? in_valid_i : in_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced beat did not reach the result register");

  a_ready_low_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled while a register was free");

  a_bad_has_syndrome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.bad_syndrome) |-> (out_data_o.error_position != '0))
    else $error("bad syndrome flagged with zero syndrome");

endmodule

// File: dv/tb_hamming_sec_codec.sv
// tb_hamming_sec_codec: self-checking testbench for the hamming sec codec
// drives encode and correct beats, predicts each result and compares it field by field
// depends on hsc_pkg and hamming_sec_codec
`timescale 1ns / 1ps

module tb_hamming_sec_codec;
  import hsc_pkg::*;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      out_ready_i = 1'b0;
  in_item_t  in_data_i   = '0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  out_item_t expected_q[$];
  out_item_t want;
  int        mismatch_cnt = 0;
  int        ready_hold   = 0;
  bit        no_idle      = 1'b0;

  hamming_sec_codec u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // expected result of one beat
  function automatic out_item_t hamming_predict(input in_item_t it);
    out_item_t        res;
    logic [CodeW-1:0] word;
    logic [63:0]      nmask;
    logic [ChkW-1:0]  checks;
    int               m, r, n, j, syn;
    bit               par;
    res    = '0;
    word   = '0;
    checks = '0;
    syn    = 0;
    m = (it.data_length > MaxDataBits) ? MaxDataBits : int'(it.data_length);
    r = 1;
    while (m + r + 1 > (1 << r)) r++;
    n = m + r;
    nmask = (64'd1 << n) - 64'd1;
    if (it.kind == KindEncode) begin
      j = 0;
      for (int p = 1; p <= n; p++) begin
        if ((p & (p - 1)) != 0) begin
          word[p-1] = it.data_in[j];
          j++;
        end
      end
    end else begin
      word = it.code_in & nmask[CodeW-1:0];
    end
    for (int i = 0; i < r; i++) begin
      par = it.odd_parity;
      for (int p = 1; p <= n; p++) begin
        if (((p & (p - 1)) != 0) && (((p >> i) & 1) == 1)) begin
          par ^= word[p-1];
        end
      end
      checks[i] = par;
    end
    if (it.kind == KindEncode) begin
      for (int i = 0; i < r; i++) word[(1 << i) - 1] = checks[i];
    end else begin
      for (int i = 0; i < r; i++) begin
        if (word[(1 << i) - 1] != checks[i]) syn += (1 << i);
      end
      if (syn > n) begin
        res.bad_syndrome = 1'b1;
      end else if (syn != 0) begin
        word[syn-1] = ~word[syn-1];
      end
    end
    res.code_out       = word & nmask[CodeW-1:0];
    res.check_bits     = checks;
    res.error_position = syn[ChkW-1:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int sel;
    if (no_idle) return 0;
    sel = $urandom_range(0, 19);
    if (sel < 8) return 0;
    if (sel < 17) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic in_item_t make_item(input kind_e k, input logic [DataW-1:0] d,
                                         input logic [CodeW-1:0] c, input int len,
                                         input bit odd);
    in_item_t it;
    it.kind        = k;
    it.data_in     = d;
    it.code_in     = c;
    it.data_length = len[LenW-1:0];
    it.odd_parity  = odd;
    return it;
  endfunction

  function automatic int rand_len();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 0;
    if (sel == 1) return $urandom_range(57, 63);
    return $urandom_range(1, 57);
  endfunction

  function automatic logic [63:0] rand_bits();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v;
  endfunction

  // one input beat; valid stays up across back-to-back beats
  task automatic drive_word(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    expected_q.push_back(hamming_predict(it));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      out_ready_i <= no_idle || ($urandom_range(0, 3) != 0);
      ready_hold = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("result beat with nothing pending: %p", out_data_o);
      end else begin
        want = expected_q.pop_front();
        if (out_data_o.code_out !== want.code_out ||
            out_data_o.check_bits !== want.check_bits ||
            out_data_o.error_position !== want.error_position ||
            out_data_o.bad_syndrome !== want.bad_syndrome) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: code_out exp %h got %h, check_bits exp %h got %h",
                     want.code_out, out_data_o.code_out, want.check_bits,
                     out_data_o.check_bits);
            $display("          error_position exp %0d got %0d, bad_syndrome exp %b got %b",
                     want.error_position, out_data_o.error_position, want.bad_syndrome,
                     out_data_o.bad_syndrome);
          end
        end
      end
    end
  end

  task automatic test_encode_extremes();
    drive_word(make_item(KindEncode, '0, '1, 0, 1'b0));
    drive_word(make_item(KindEncode, '1, '0, 1, 1'b1));
    drive_word(make_item(KindEncode, '1, '0, 57, 1'b0));
    drive_word(make_item(KindEncode, '0, '1, 57, 1'b1));
    drive_word(make_item(KindEncode, '1, '1, 63, 1'b0));
    // data bits beyond the length are ignored
    drive_word(make_item(KindEncode, '1, '0, 5, 1'b1));
  endtask

  task automatic test_correct_cases();
    out_item_t   cw;
    out_item_t   probe;
    in_item_t    it;
    logic [63:0] bits;
    cw = hamming_predict(make_item(KindEncode, '1, '0, 57, 1'b1));
    drive_word(make_item(KindCorrect, '0, cw.code_out, 57, 1'b1));
    drive_word(make_item(KindCorrect, '0, cw.code_out ^ (63'd1 << 62), 57, 1'b1));
    drive_word(make_item(KindCorrect, '0, cw.code_out ^ 63'd1, 57, 1'b1));
    drive_word(make_item(KindCorrect, '0, cw.code_out ^ (63'd1 << 2), 57, 1'b1));
    // single check bit only, unused code bits set
    drive_word(make_item(KindCorrect, '1, '1, 0, 1'b0));
    // syndrome past the end of a short word
    for (int odd = 0; odd < 2; odd++) begin
      do begin
        bits  = rand_bits();
        it    = make_item(KindCorrect, '0, bits[CodeW-1:0], 2, odd[0]);
        probe = hamming_predict(it);
      end while (!probe.bad_syndrome);
      drive_word(it);
    end
    // length above the limit saturates
    bits = rand_bits();
    cw = hamming_predict(make_item(KindEncode, bits[DataW-1:0], '0, 63, 1'b0));
    drive_word(make_item(KindCorrect, '0, cw.code_out ^ (63'd1 << 4), 63, 1'b0));
    // junk above the code length with one flipped bit
    cw = hamming_predict(make_item(KindEncode, 57'h9, '0, 4, 1'b1));
    drive_word(make_item(KindCorrect, '0, (cw.code_out | ({CodeW{1'b1}} << 7)) ^ 63'h20,
                         4, 1'b1));
  endtask

  task automatic test_encode_correct_pairs(input int pairs);
    out_item_t   cw;
    logic [63:0] bits, noise;
    logic [CodeW-1:0] word;
    int          len, n, sel;
    bit          odd;
    for (int k = 0; k < pairs; k++) begin
      len  = rand_len();
      odd  = 1'($urandom_range(0, 1));
      bits = rand_bits();
      drive_word(make_item(KindEncode, bits[DataW-1:0], bits[CodeW-1:0], len, odd));
      cw   = hamming_predict(make_item(KindEncode, bits[DataW-1:0], '0, len, odd));
      word = cw.code_out;
      n    = (len > MaxDataBits) ? MaxDataBits : len;
      n    = n + $clog2(n + $clog2(n + 1) + 1);
      if (len == 0) n = 1;
      sel  = $urandom_range(0, 19);
      if (sel >= 6) word[$urandom_range(0, n - 1)] ^= 1'b1;
      if (sel >= 17) word[$urandom_range(0, n - 1)] ^= 1'b1;
      if (sel % 4 == 1) begin
        noise = rand_bits();
        word  = word ^ (noise[CodeW-1:0] & ({CodeW{1'b1}} << n));
      end
      noise = rand_bits();
      drive_word(make_item(KindCorrect, noise[DataW-1:0], word, len, odd));
    end
  endtask

  task automatic test_random_noise(input int beats);
    logic [63:0] d, c;
    for (int k = 0; k < beats; k++) begin
      d = rand_bits();
      c = rand_bits();
      drive_word(make_item(kind_e'($urandom_range(0, 1)), d[DataW-1:0], c[CodeW-1:0],
                           $urandom_range(0, 63), 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic test_back_to_back(input int pairs);
    no_idle = 1'b1;
    test_encode_correct_pairs(pairs);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_encode_extremes();
    test_correct_cases();
    test_back_to_back(20);
    test_encode_correct_pairs(450);
    test_back_to_back(10);
    test_random_noise(180);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
